// ===== hdl/assert_macros.svh =====
// assertion macros for the request queue
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, expr)

`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== hdl/lbaq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lbaq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int OCC_W       = 5;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_FULL     = 2'd1,
    ST_DEQUEUED = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0]  tag;
    logic [1:0]  op;
    logic [15:0] count;
    logic [31:0] addr;
  } entry_t;

  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t ent;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/lbaq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lbaq_cell
  import lbaq_pkg::*;
(
  input  wire logic       clk,
  input  wire cell_ctrl_t ctrl,
  input  wire logic       occupied,
  input  wire logic       left_ge,
  input  wire entry_t     left_entry,
  input  wire entry_t     right_entry,
  output logic            ge,
  output entry_t          entry
);

  // free cell or stored address not below the new one
  assign ge = !occupied || (entry.addr >= ctrl.ent.addr);

  always_ff @(posedge clk) begin
    if (ctrl.enq) begin
      if (left_ge) begin
        entry <= left_entry;
      end else if (ge) begin
        entry <= ctrl.ent;
      end
    end else if (ctrl.deq) begin
      entry <= right_entry;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lba_sorted_request_queue_core.sv =====
// each result is registered in the cycle after its input transfer
// throughput: one item per cycle, every cell compares the broadcast address at once
// the input stalls only while the result register holds a result not yet taken
// reset: entry count and result valid cleared, cell contents left undefined
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lba_sorted_request_queue_core
  import lbaq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // block_addr, block_count, operation, requester_tag, zero pad
  input  wire logic [63:0] s_axis_tdata,
  // cmd
  input  wire logic [0:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // out_block_addr, out_block_count, out_operation, out_tag, occupancy, zero pad
  output logic [63:0]      m_axis_tdata,
  // status
  output logic [1:0]       m_axis_tuser
);

  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;
  logic                   accept;
  logic                   is_enq;
  logic                   full;
  logic                   empty;
  cell_ctrl_t             ctrl;
  entry_t                 cell_entry [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_ge;
  logic [QUEUE_DEPTH-1:0] cell_occ;
  status_t                res_status;
  status_t                res_status_next;
  entry_t                 res_entry;
  entry_t                 res_entry_next;
  logic [CNT_W-1:0]       res_count;
  logic                   res_valid;

  assign s_axis_tready = !res_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_enq        = (cmd_t'(s_axis_tuser[0]) == CMD_ENQ);
  assign full          = (count == CNT_W'(QUEUE_DEPTH));
  assign empty         = (count == '0);

  always_comb begin
    ctrl.enq       = accept && is_enq && !full;
    ctrl.deq       = accept && !is_enq && !empty;
    ctrl.ent.addr  = s_axis_tdata[31:0];
    ctrl.ent.count = s_axis_tdata[47:32];
    ctrl.ent.op    = s_axis_tdata[49:48];
    ctrl.ent.tag   = s_axis_tdata[57:50];
    count_next     = count;
    res_entry_next = '0;
    if (is_enq) begin
      if (full) begin
        res_status_next = ST_FULL;
      end else begin
        res_status_next = ST_ENQUEUED;
        count_next      = count + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        res_status_next = ST_EMPTY;
      end else begin
        res_status_next = ST_DEQUEUED;
        res_entry_next  = cell_entry[0];
        count_next      = count - CNT_W'(1);
      end
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic   left_ge;
    entry_t left_entry;
    entry_t right_entry;

    assign cell_occ[i] = (CNT_W'(i) < count);

    if (i == 0) begin : g_head
      assign left_ge    = 1'b0;
      assign left_entry = '0;
    end else begin : g_body
      assign left_ge    = cell_ge[i-1];
      assign left_entry = cell_entry[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_entry = '0;
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    lbaq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (cell_occ[i]),
      .left_ge     (left_ge),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .ge          (cell_ge[i]),
      .entry       (cell_entry[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        res_valid <= 1'b1;
      end else if (m_axis_tready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_status <= res_status_next;
      res_entry  <= res_entry_next;
      res_count  <= count_next;
    end
  end

  assign m_axis_tvalid = res_valid;
  assign m_axis_tuser  = res_status;
  assign m_axis_tdata  = {1'b0, OCC_W'(res_count), res_entry};

  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CNT_W'(QUEUE_DEPTH))
  `ASSERT_NEXT(a_enq_grows, clk, rst, ctrl.enq, count == $past(count) + CNT_W'(1))
  `ASSERT_NEXT(a_deq_shrinks, clk, rst, ctrl.deq, count == $past(count) - CNT_W'(1))
  `ASSERT_NEXT(a_result_follows, clk, rst, accept, m_axis_tvalid)

  for (genvar k = 1; k < QUEUE_DEPTH; k++) begin : g_order
    `ASSERT_ALWAYS(a_sorted, clk, rst,
      !cell_occ[k] || (cell_entry[k-1].addr <= cell_entry[k].addr))
  end

endmodule

`default_nettype wire
